// File: hw/rtl/gasp_pkg.sv
// Shared types and constants for the glyph atlas shelf packer.
package gasp_pkg;

  // Glyph store geometry.
  localparam int MaxGlyphs = 64;
  localparam int AddrW     = (MaxGlyphs > 1) ? $clog2(MaxGlyphs) : 1;
  localparam int CountW    = $clog2(MaxGlyphs + 1);

  // Field widths.
  localparam int DimW  = 8;
  localparam int CodeW = 8;
  localparam int PosXW = 12;
  localparam int PosYW = 14;
  localparam int SizeW = 13;

  // Atlas side is 2**exp with exp running from StartExp up to CapExp.
  localparam int ExpW     = 4;
  localparam int StartExp = 4;
  localparam int CapExp   = 12;

  // Quotient of the side by a dimension, and the product of two quotients.
  localparam int QuotW = SizeW;
  localparam int ProdW = 2 * QuotW;

  // One stored glyph.
  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [DimW-1:0]  width;
    logic [DimW-1:0]  height;
  } glyph_entry_t;

  // Request into the size search unit.
  typedef struct packed {
    logic              start;
    logic [DimW-1:0]   widest;
    logic [DimW-1:0]   tallest;
    logic [CountW-1:0] count;
  } size_req_t;

  // Answer from the size search unit.
  typedef struct packed {
    logic             done;
    logic [SizeW-1:0] size;
  } size_res_t;

endpackage

// File: hw/rtl/glyph_atlas_shelf_packer.sv
// Top level of the glyph atlas shelf packer: load, size search and placement.
//
// Usage: glyph sizes enter on the s_axis channel, one request per cycle while
// s_axis_tready is high. s_axis_tlast marks the final glyph of a set. Up to
// 64 glyphs are kept; further glyphs of the same set are dropped, but their
// tlast still starts packing. After the final glyph the input stalls while
// the atlas side is searched, driven by the iterative divider in the size
// search unit. Then one placement per stored glyph leaves on m_axis in load
// order, with tlast on the last one. Each placement passes through a store
// read, a compute step and an output step when the receiver is ready; a
// stall on m_axis_tready holds the placement and the whole packing pass.
// Reset empties the set and leaves the block ready to load; the glyph store
// itself is not cleared, since only entries written in the current set are
// read.
module glyph_atlas_shelf_packer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // glyph_code[7:0], glyph_width[15:8], glyph_height[23:16]
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_code[7:0], pos_x[19:8], pos_y[33:20], out_width[41:34],
  // out_height[49:42], atlas_size[62:50], zero[63]
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_SIZE  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_PLACE = 3'd4;
  localparam logic [2:0] ST_SEND  = 3'd5;

  logic [2:0]                       state;
  logic [gasp_pkg::CountW-1:0]      count;
  logic [gasp_pkg::DimW-1:0]        widest;
  logic [gasp_pkg::DimW-1:0]        tallest;
  logic [gasp_pkg::CountW-1:0]      idx;
  logic [gasp_pkg::SizeW-1:0]       side;
  logic [gasp_pkg::PosXW-1:0]       cursor_x;
  logic [gasp_pkg::PosYW-1:0]       cursor_y;
  logic [gasp_pkg::DimW-1:0]        shelf_height;
  logic                             out_valid;
  logic                             out_last;
  gasp_pkg::glyph_entry_t           out_glyph;
  logic [gasp_pkg::PosXW-1:0]       out_x;
  logic [gasp_pkg::PosYW-1:0]       out_y;

  gasp_pkg::glyph_entry_t           in_glyph;
  gasp_pkg::glyph_entry_t           rd_glyph;
  gasp_pkg::size_req_t              size_req;
  gasp_pkg::size_res_t              size_res;
  logic                             in_accept;
  logic                             store_room;
  logic [gasp_pkg::DimW-1:0]        shelf_next;
  logic [gasp_pkg::SizeW-1:0]       reach;
  logic                             wrap;
  logic [gasp_pkg::PosXW-1:0]       place_x;
  logic [gasp_pkg::PosYW-1:0]       place_y;

  // Input request unpacking.
  assign in_glyph.code   = s_axis_tdata[7:0];
  assign in_glyph.width  = s_axis_tdata[15:8];
  assign in_glyph.height = s_axis_tdata[23:16];

  assign s_axis_tready = (state == ST_LOAD);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign store_room    = count < gasp_pkg::CountW'(gasp_pkg::MaxGlyphs);

  // Glyph store.
  gasp_glyph_ram u_ram (
    .clk   (clk),
    .we    (in_accept && store_room),
    .waddr (count[gasp_pkg::AddrW-1:0]),
    .wdata (in_glyph),
    .raddr (idx[gasp_pkg::AddrW-1:0]),
    .rdata (rd_glyph)
  );

  // Size search unit.
  assign size_req.start   = (state == ST_START);
  assign size_req.widest  = widest;
  assign size_req.tallest = tallest;
  assign size_req.count   = count;

  gasp_size_search u_size (
    .clk (clk),
    .rst (rst),
    .req (size_req),
    .res (size_res)
  );

  // Shelf placement of the glyph just read from the store.
  assign shelf_next = (rd_glyph.height > shelf_height) ? rd_glyph.height : shelf_height;
  assign reach      = gasp_pkg::SizeW'(cursor_x) + gasp_pkg::SizeW'(rd_glyph.width);
  assign wrap       = reach >= side;
  assign place_x    = wrap ? '0 : cursor_x;
  assign place_y    = wrap ? gasp_pkg::PosYW'(cursor_y + gasp_pkg::PosYW'(shelf_next))
                           : cursor_y;

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      widest    <= '0;
      tallest   <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (in_accept) begin
            if (store_room) begin
              count <= count + 1'b1;
              if (in_glyph.width > widest) widest <= in_glyph.width;
              if (in_glyph.height > tallest) tallest <= in_glyph.height;
            end
            if (s_axis_tlast) state <= ST_START;
          end
        end
        ST_START: state <= ST_SIZE;
        ST_SIZE: begin
          if (size_res.done) begin
            idx   <= '0;
            state <= ST_READ;
          end
        end
        ST_READ: state <= ST_PLACE;
        ST_PLACE: begin
          out_valid <= 1'b1;
          state     <= ST_SEND;
        end
        ST_SEND: begin
          if (m_axis_tready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              count   <= '0;
              widest  <= '0;
              tallest <= '0;
              state   <= ST_LOAD;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_READ;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // Cursor, shelf and output payload registers.
  always_ff @(posedge clk) begin
    if (state == ST_SIZE && size_res.done) begin
      side         <= size_res.size;
      cursor_x     <= '0;
      cursor_y     <= '0;
      shelf_height <= '0;
    end
    if (state == ST_PLACE) begin
      shelf_height <= shelf_next;
      cursor_y     <= place_y;
      cursor_x     <= gasp_pkg::PosXW'(place_x + gasp_pkg::PosXW'(rd_glyph.width));
      out_glyph    <= rd_glyph;
      out_x        <= place_x;
      out_y        <= place_y;
      out_last     <= (idx + 1'b1 == count);
    end
  end

  // Output request packing.
  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {1'b0, side, out_glyph.height, out_glyph.width,
                          out_y, out_x, out_glyph.code};

  // The input and output never carry requests at the same time.
  assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a placement is pending");

  // The store fill never passes its depth.
  assert property (@(posedge clk) disable iff (rst)
    count <= gasp_pkg::CountW'(gasp_pkg::MaxGlyphs))
    else $error("glyph count beyond store depth");

  // Packing only runs on a non-empty set.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ || state == ST_PLACE || state == ST_SEND) |-> count != '0)
    else $error("packing pass with an empty set");

  // A placed glyph starts inside the atlas.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (gasp_pkg::SizeW'(out_x) < side))
    else $error("placement left edge outside the atlas");

  // The searched side is a power of two of at least the start size.
  assert property (@(posedge clk) disable iff (rst)
    size_res.done |-> ($onehot(size_res.size) && size_res.size[3:0] == 4'd0))
    else $error("atlas side is not a valid power of two");

endmodule

// File: hw/rtl/gasp_glyph_ram.sv
// Glyph store: single write port, single read port, registered read data.
module gasp_glyph_ram (
  input  logic                         clk,
  input  logic                         we,
  input  logic [gasp_pkg::AddrW-1:0]   waddr,
  input  gasp_pkg::glyph_entry_t       wdata,
  input  logic [gasp_pkg::AddrW-1:0]   raddr,
  output gasp_pkg::glyph_entry_t       rdata
);

  gasp_pkg::glyph_entry_t mem [gasp_pkg::MaxGlyphs];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/gasp_size_search.sv
// Atlas size search: doubles a power-of-two side until the glyphs fit or the side reaches its cap.
module gasp_size_search (
  input  logic                clk,
  input  logic                rst,
  input  gasp_pkg::size_req_t req,
  output gasp_pkg::size_res_t res
);

  localparam logic [1:0] SS_IDLE = 2'd0;
  localparam logic [1:0] SS_STEP = 2'd1;
  localparam logic [1:0] SS_MUL  = 2'd2;
  localparam logic [1:0] SS_CMP  = 2'd3;

  logic [1:0]                       state;
  logic [1:0]                       state_next;
  logic [gasp_pkg::ExpW-1:0]        exp;
  logic [gasp_pkg::DimW-1:0]        div_w;
  logic [gasp_pkg::DimW-1:0]        div_h;
  logic [gasp_pkg::QuotW-1:0]       quot_w;
  logic [gasp_pkg::QuotW-1:0]       quot_h;
  logic [gasp_pkg::DimW-1:0]        rem_w;
  logic [gasp_pkg::DimW-1:0]        rem_h;
  logic [gasp_pkg::CountW-1:0]      count;
  logic [gasp_pkg::ProdW-1:0]       prod;
  logic [gasp_pkg::DimW-1:0]        req_w;
  logic [gasp_pkg::DimW-1:0]        req_h;
  logic [gasp_pkg::DimW:0]          rem2_w;
  logic [gasp_pkg::DimW:0]          rem2_h;
  logic                             ge_w;
  logic                             ge_h;
  logic                             grow;

  // A zero dimension counts as one.
  assign req_w = (req.widest  == '0) ? gasp_pkg::DimW'(1) : req.widest;
  assign req_h = (req.tallest == '0) ? gasp_pkg::DimW'(1) : req.tallest;

  // One restoring division step per doubling of the side.
  assign rem2_w = {rem_w, 1'b0};
  assign rem2_h = {rem_h, 1'b0};
  assign ge_w   = rem2_w >= {1'b0, div_w};
  assign ge_h   = rem2_h >= {1'b0, div_h};

  // Keep doubling while the grid holds fewer cells than glyphs and the side is below its cap.
  assign grow = (prod < gasp_pkg::ProdW'(count)) &&
                (exp < gasp_pkg::ExpW'(gasp_pkg::CapExp));

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      SS_IDLE: begin
        if (req.start) state_next = SS_STEP;
      end
      SS_STEP: begin
        if (exp + 1'b1 >= gasp_pkg::ExpW'(gasp_pkg::StartExp)) state_next = SS_MUL;
      end
      SS_MUL: state_next = SS_CMP;
      SS_CMP: state_next = grow ? SS_STEP : SS_IDLE;
      default: state_next = SS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: quotients and remainders of 2**exp by each dimension.
  always_ff @(posedge clk) begin
    if (state == SS_IDLE && req.start) begin
      div_w  <= req_w;
      div_h  <= req_h;
      count  <= req.count;
      exp    <= '0;
      quot_w <= (req_w == gasp_pkg::DimW'(1)) ? gasp_pkg::QuotW'(1) : '0;
      quot_h <= (req_h == gasp_pkg::DimW'(1)) ? gasp_pkg::QuotW'(1) : '0;
      rem_w  <= (req_w == gasp_pkg::DimW'(1)) ? '0 : gasp_pkg::DimW'(1);
      rem_h  <= (req_h == gasp_pkg::DimW'(1)) ? '0 : gasp_pkg::DimW'(1);
    end else if (state == SS_STEP) begin
      exp    <= exp + 1'b1;
      quot_w <= {quot_w[gasp_pkg::QuotW-2:0], ge_w};
      quot_h <= {quot_h[gasp_pkg::QuotW-2:0], ge_h};
      rem_w  <= ge_w ? gasp_pkg::DimW'(rem2_w - {1'b0, div_w}) : rem2_w[gasp_pkg::DimW-1:0];
      rem_h  <= ge_h ? gasp_pkg::DimW'(rem2_h - {1'b0, div_h}) : rem2_h[gasp_pkg::DimW-1:0];
    end
    if (state == SS_MUL) begin
      prod <= quot_w * quot_h;
    end
  end

  // Result is valid for one cycle as the search ends.
  assign res.done = (state == SS_CMP) && !grow;
  assign res.size = gasp_pkg::SizeW'(1) << exp;

endmodule
